// File: rtl/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int FRAME_W     = 15;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int CNT_W       = 16;
  localparam int FRAME_LIMIT = 32768;

  localparam logic [1:0] OP_ALLOC_FIRST = 2'd0;
  localparam logic [1:0] OP_ALLOC_AT    = 2'd1;
  localparam logic [1:0] OP_FREE        = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_SKIP   = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 16'h8000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               page_exists;
    logic [FRAME_W-1:0] page_frame_now;
    logic [FRAME_W-1:0] frame_index;
    logic               is_kernel;
    logic               is_writable;
  } fba_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] page_frame_new;
    logic               present;
    logic               writable;
    logic               user;
  } fba_rsp_t;

  // Position of the lowest clear bit; only meaningful when one exists.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

// File: rtl/fba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fba_seq.sv
// Request sequencer: bitmap clearing pass, word scan and read-modify-write.
`timescale 1ns / 1ps

module fba_seq import fba_pkg::*; #(
  parameter int MAX_FRAMES = 32768,
  localparam int LIM_CAP = (MAX_FRAMES < FRAME_LIMIT) ? MAX_FRAMES : FRAME_LIMIT,
  localparam int WORDS   = (LIM_CAP + WORD_W - 1) / WORD_W,
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CNT_W-1:0]   frame_count_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  fba_req_t           req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output fba_rsp_t           rsp_o,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [WORD_W-1:0]  mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  logic [WORD_W-1:0]  mem_rdata_i
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_WAIT  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_MOD   = 6'b100000
  } seq_state_e;

  localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(LIM_CAP);

  seq_state_e         state_q, state_d;
  logic               rsp_pend_q, rsp_pend_d;
  fba_req_t           req_q, req_d;
  fba_rsp_t           rsp_q, rsp_d;
  logic [CNT_W-1:0]   lim_q, lim_d;
  logic [AW:0]        words_q, words_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [AW:0]        scan_q, scan_d;
  logic [AW-1:0]      rd_addr_q, rd_addr_d;
  logic               rdv_q, rdv_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [FRAME_W-1:0] target_q, target_d;
  logic               set_q, set_d;

  logic [CNT_W-1:0]   lim_now;
  logic [CNT_W+1:0]   words_sum;
  logic [BIT_W-1:0]   zero_pos;
  logic [FRAME_W-1:0] found_frame;
  logic [WORD_W-1:0]  bit_mask;
  fba_rsp_t           skip_rsp;

  assign lim_now     = (frame_count_i > LIM_MAX) ? LIM_MAX : frame_count_i;
  assign words_sum   = (CNT_W + 2)'(lim_now) + (CNT_W + 2)'(WORD_W - 1);
  assign zero_pos    = lowest_zero(mem_rdata_i);
  assign found_frame = FRAME_W'({rd_addr_q, zero_pos});
  assign bit_mask    = WORD_W'(1) << target_q[BIT_W-1:0];

  always_comb begin
    skip_rsp                = '0;
    skip_rsp.status         = ST_SKIP;
    skip_rsp.page_frame_new = req_i.page_frame_now;
  end

  assign req_ready_o = (state_q == S_IDLE) && !rsp_pend_q;
  assign rsp_valid_o = rsp_pend_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d     = state_q;
    rsp_pend_d  = rsp_pend_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    lim_d       = lim_q;
    words_d     = words_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    rd_addr_d   = rd_addr_q;
    rdv_d       = rdv_q;
    word_d      = word_q;
    target_d    = target_q;
    set_d       = set_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = target_q[AW+BIT_W-1:BIT_W];
    mem_wdata_o = set_q ? (word_q | bit_mask) : (word_q & ~bit_mask);
    mem_re_o    = 1'b0;
    mem_raddr_o = target_q[AW+BIT_W-1:BIT_W];

    if (rsp_pend_q && rsp_ready_i) rsp_pend_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          req_d   = req_i;
          lim_d   = lim_now;
          words_d = (AW + 1)'(words_sum >> BIT_W);
          rsp_d   = skip_rsp;
          scan_d  = '0;
          rdv_d   = 1'b0;
          if (!req_i.page_exists) begin
            rsp_pend_d = 1'b1;
          end else if (req_i.opcode == OP_ALLOC_FIRST || req_i.opcode == OP_ALLOC_AT) begin
            if (req_i.page_frame_now != '0) begin
              rsp_pend_d = 1'b1;
            end else if (req_i.opcode == OP_ALLOC_FIRST) begin
              if (lim_now == '0) begin
                rsp_d.status = ST_NOFREE;
                rsp_pend_d   = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end else if (CNT_W'(req_i.frame_index) >= lim_now) begin
              rsp_d.status = ST_RANGE;
              rsp_pend_d   = 1'b1;
            end else begin
              target_d = req_i.frame_index;
              set_d    = 1'b1;
              state_d  = S_ADDR;
            end
          end else if (req_i.opcode == OP_FREE) begin
            if (req_i.page_frame_now == '0) begin
              rsp_pend_d = 1'b1;
            end else if (CNT_W'(req_i.page_frame_now) >= lim_now) begin
              rsp_d.status = ST_RANGE;
              rsp_pend_d   = 1'b1;
            end else begin
              target_d = req_i.page_frame_now;
              set_d    = 1'b0;
              state_d  = S_ADDR;
            end
          end else begin
            rsp_pend_d = 1'b1;
          end
        end
      end
      S_ADDR: begin
        mem_re_o = 1'b1;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        word_d  = mem_rdata_i;
        state_d = S_MOD;
      end
      S_SCAN: begin
        // Stream one word read per cycle; read data returns in the cycle after its address.
        mem_raddr_o = scan_q[AW-1:0];
        mem_re_o    = (scan_q < words_q);
        rdv_d       = mem_re_o;
        if (mem_re_o) begin
          rd_addr_d = scan_q[AW-1:0];
          scan_d    = scan_q + (AW + 1)'(1);
        end
        if (rdv_q) begin
          if (mem_rdata_i != '1) begin
            if (CNT_W'(found_frame) >= lim_q) begin
              rsp_d.status = ST_NOFREE;
              rsp_pend_d   = 1'b1;
              state_d      = S_IDLE;
            end else begin
              word_d   = mem_rdata_i;
              target_d = found_frame;
              set_d    = 1'b1;
              state_d  = S_MOD;
            end
          end else if ((AW + 1)'(rd_addr_q) == words_q - (AW + 1)'(1)) begin
            rsp_d.status = ST_NOFREE;
            rsp_pend_d   = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_MOD: begin
        mem_we_o     = 1'b1;
        rsp_d        = '0;
        rsp_d.status = ST_DONE;
        if (set_q) begin
          rsp_d.page_frame_new = target_q;
          rsp_d.present        = 1'b1;
          rsp_d.writable       = req_q.is_writable;
          rsp_d.user           = ~req_q.is_kernel;
        end
        rsp_pend_d = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      rsp_pend_q <= 1'b0;
      clr_q      <= '0;
      scan_q     <= '0;
      rdv_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      rsp_pend_q <= rsp_pend_d;
      clr_q      <= clr_d;
      scan_q     <= scan_d;
      rdv_q      <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rsp_q     <= rsp_d;
    lim_q     <= lim_d;
    words_q   <= words_d;
    rd_addr_q <= rd_addr_d;
    word_q    <= word_d;
    target_q  <= target_d;
    set_q     <= set_d;
  end

endmodule

// File: rtl/frame_bitmap_allocator_unit.sv
// Fixed-index allocate and free read the bitmap word, wait for its data, then write it back
// modified and register the result; skipped and rejected requests register it on accept.
// First-free allocation scans up to (frame_count+31)/32 bitmap words, one RAM read per cycle.
// A new request is taken once the previous result has left the sequencer.
// Reset: frame_count returns to 32768; the bitmap RAM is cleared one word per cycle,
// all (MAX_FRAMES+31)/32 words capped at 1024, before the first request is taken.
`timescale 1ns / 1ps

module frame_bitmap_allocator_unit import fba_pkg::*; #(
  parameter int MAX_FRAMES = 32768
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fba_req_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fba_rsp_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i
);

  localparam int LIM_CAP = (MAX_FRAMES < FRAME_LIMIT) ? MAX_FRAMES : FRAME_LIMIT;
  localparam int WORDS   = (LIM_CAP + WORD_W - 1) / WORD_W;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [CNT_W-1:0]  frame_count_q;
  logic              out_valid_q;
  fba_rsp_t          out_data_q;

  logic              req_ready;
  logic              rsp_valid;
  logic              rsp_ready;
  fba_rsp_t          rsp;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_wdata_i;
    end
  end

  fba_seq #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_count_i (frame_count_q),
    .req_valid_i   (in_valid_i),
    .req_ready_o   (req_ready),
    .req_i         (in_data_i),
    .rsp_valid_o   (rsp_valid),
    .rsp_ready_i   (rsp_ready),
    .rsp_o         (rsp),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  fba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: refill when empty or when the held transaction leaves.
  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) out_data_q <= rsp;
  end

  assign in_stall_o  = !req_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
